### sv/sph_gd_pkg.sv
// Shared types and constants for the SPH grid deposit block.
// No dependencies; imported by every module of the block but sph_ram.
package sph_gd_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int GRID_LOG2_MAX = 6;
    localparam int SPAN_MAX      = 8;
    localparam int GRID_AW       = 2 * GRID_LOG2_MAX;
    localparam int GRID_W        = 48;
    localparam int KBUF_W        = FRAC_BITS + 1;
    localparam int SUM_W         = 23;
    localparam int DIV_W         = 49;
    localparam int RAD_W         = 32;
    localparam int ROOT_W        = RAD_W / 2;

    typedef enum logic [1:0] {
        CMD_DEPOSIT = 2'd0,
        CMD_READ    = 2'd1,
        CMD_CLEAR   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SPAN  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [SUM_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [RAD_W-1:0]   radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic               done;
        logic [ROOT_W-1:0]  root;
    } sqrt_rsp_t;

endpackage

### sv/sph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/sph_gd_isqrt.sv
// Serial integer square root, two radicand bits per cycle.
// Depends on sph_gd_pkg for the request and response structs.
module sph_gd_isqrt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sph_gd_pkg::sqrt_req_t req,
    output sph_gd_pkg::sqrt_rsp_t rsp
);
    import sph_gd_pkg::*;

    localparam int CW = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic              ge;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (ge) begin
                rem_reg  <= ROOT_W'(0) + (ROOT_W+2)'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= (ROOT_W+2)'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

### sv/sph_gd_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on sph_gd_pkg for the request and response structs.
module sph_gd_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sph_gd_pkg::div_req_t req,
    output sph_gd_pkg::div_rsp_t rsp
);
    import sph_gd_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic [DIV_W-1:0] qd_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [SUM_W:0]   sh;
    logic [SUM_W:0]   diff;
    logic             ge;

    assign sh   = {rem_reg, qd_reg[DIV_W-1]};
    assign ge   = sh >= {1'b0, dvs_reg};
    assign diff = sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            qd_reg  <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            qd_reg  <= {qd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[SUM_W-1:0] : sh[SUM_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = qd_reg;

endmodule

### sv/sph_grid_deposit.sv
// SPH cubic-spline particle-to-grid deposit on a periodic 2D grid.
// Depends on sph_gd_pkg, sph_ram, sph_gd_isqrt and sph_gd_div.
//
// Requests enter on s_valid/s_ready; one result per request leaves on
// m_valid/m_ready. Commands: deposit a particle, read one cell, clear grid.
// cfg_wr_en/cfg_wr_data set log2 of the grid size (values above 6 act as 6).
// The grid accumulators live in one 4096 x 96 RAM (quantity, weight); the
// kernel values of the footprint live in a 64 x 17 RAM.
// One request is worked at a time; s_ready is high only when idle.
// Read: ST_RDADDR, ST_RDDATA. Clear: zeroes every grid word. Command 3: to ST_DONE.
// Deposit: a setup step, then a kernel pass over the footprint cells, using
// the serial square root and the serial divider (one quotient bit per cycle)
// for a cell inside the radius, then an accumulate pass that divides again
// per cell; a full footprint is 8 x 8 cells. One-cell footprints go from
// setup straight to the accumulate step, span-rejected ones to ST_DONE.
// After reset the block sweeps all 4096 grid RAM words to zero with
// s_ready low. A finished result waits in the output register while m_ready
// is low; the block stalls before producing the next result.
module sph_grid_deposit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [15:0]         s_pos_x,
    input  logic [15:0]         s_pos_y,
    input  logic [15:0]         s_radius,
    input  logic signed [31:0]  s_quantity,
    input  logic [31:0]         s_weight,
    input  logic [5:0]          s_cell_x,
    input  logic [5:0]          s_cell_y,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic signed [47:0]  m_cell_quantity,
    output logic [47:0]         m_cell_weight
);
    import sph_gd_pkg::*;

    localparam logic [16:0] ONE  = 17'd1 << FRAC_BITS;
    localparam logic [15:0] HALF = 16'd1 << (FRAC_BITS - 1);

    typedef enum logic [18:0] {
        ST_IDLE   = 19'h00001,
        ST_CLEAR  = 19'h00002,
        ST_SETUP  = 19'h00004,
        ST_SQ     = 19'h00008,
        ST_CMP    = 19'h00010,
        ST_SQRT   = 19'h00020,
        ST_UDIV   = 19'h00040,
        ST_KP1    = 19'h00080,
        ST_KP2    = 19'h00100,
        ST_KP3    = 19'h00200,
        ST_P1END  = 19'h00400,
        ST_P2RD   = 19'h00800,
        ST_P2MUL  = 19'h01000,
        ST_TWDIV  = 19'h02000,
        ST_GRD    = 19'h04000,
        ST_GWR    = 19'h08000,
        ST_RDADDR = 19'h10000,
        ST_RDDATA = 19'h20000,
        ST_DONE   = 19'h40000
    } state_t;

    function automatic logic signed [17:0] wrap_diff(input logic [15:0] p,
                                                     input logic [5:0]  c,
                                                     input logic [4:0]  s);
        logic [16:0]        centre;
        logic signed [17:0] d;
        centre = ({11'd0, c} << s) + (17'd1 << (s - 5'd1));
        d = $signed({2'b00, p}) - $signed({1'b0, centre});
        if (d > 18'sd32768) begin
            d = d - 18'sd65536;
        end else if (d < -18'sd32768) begin
            d = d + 18'sd65536;
        end
        return d;
    endfunction

    state_t state_reg, state_next;
    logic [GRID_AW-1:0] clr_addr_reg, clr_addr_next;
    logic clr_cmd_reg, clr_cmd_next;
    logic [2:0] glog_reg;
    logic m_valid_reg, m_valid_next;

    logic [15:0] px_reg, px_next, py_reg, py_next, r_reg, r_next;
    logic signed [31:0] q_reg, q_next;
    logic [31:0] wt_reg, wt_next;
    logic [5:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [2:0] nxm1_reg, nxm1_next, nym1_reg, nym1_next;
    logic [2:0] a_reg, a_next, b_reg, b_next;
    logic [31:0] r2_reg, r2_next, sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [15:0] u_reg, u_next, h_reg, h_next;
    logic [30:0] p_reg, p_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [31:0] tw_reg, tw_next;
    logic [47:0] addq_reg, addq_next;
    status_t status_reg, status_next;
    logic [47:0] rq_reg, rq_next, rw_reg, rw_next;
    logic [1:0] m_status_reg, m_status_next;
    logic [47:0] m_q_reg, m_q_next, m_w_reg, m_w_next;

    logic [2:0] g_eff;
    logic [4:0] s_sh;
    logic [5:0] mask6;
    logic [5:0] cx, cy;
    logic [GRID_AW-1:0] gaddr;
    logic [17:0] lox, hix, loy, hiy, spanx, spany;
    logic signed [17:0] dx, dy;
    logic signed [35:0] sqx_full, sqy_full;
    logic [31:0] d2;
    logic [15:0] kx;
    logic [31:0] kx2;
    logic [16:0] om_u;
    logic [33:0] om_h;
    logic [33:0] p6;
    logic [16:0] kw;
    logic [48:0] wtw;
    logic signed [64:0] qprod;
    logic signed [48:0] nq;
    logic [48:0] nw;
    logic [47:0] nq_sat, nw_sat;

    logic grid_we;
    logic [GRID_AW-1:0] grid_waddr;
    logic [2*GRID_W-1:0] grid_wdata, grid_rdata;
    logic kbuf_we;
    logic [KBUF_W-1:0] kbuf_rdata;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    assign g_eff = (glog_reg > 3'(GRID_LOG2_MAX)) ? 3'(GRID_LOG2_MAX) : glog_reg;
    assign s_sh  = 5'(FRAC_BITS) - {2'b00, g_eff};
    assign mask6 = 6'((7'd1 << g_eff) - 7'd1);
    assign cx    = (ax_reg + {3'b000, a_reg}) & mask6;
    assign cy    = (ay_reg + {3'b000, b_reg}) & mask6;
    assign gaddr = {cx, cy};

    assign lox   = ({2'b00, px_reg} + {ONE, 1'b0} - {2'b00, r_reg}) >> s_sh;
    assign hix   = ({2'b00, px_reg} + {ONE, 1'b0} + {2'b00, r_reg}) >> s_sh;
    assign loy   = ({2'b00, py_reg} + {ONE, 1'b0} - {2'b00, r_reg}) >> s_sh;
    assign hiy   = ({2'b00, py_reg} + {ONE, 1'b0} + {2'b00, r_reg}) >> s_sh;
    assign spanx = hix - lox;
    assign spany = hiy - loy;

    assign dx       = wrap_diff(px_reg, cx, s_sh);
    assign dy       = wrap_diff(py_reg, cy, s_sh);
    assign sqx_full = dx * dx;
    assign sqy_full = dy * dy;
    assign d2       = sqx_reg + sqy_reg;

    assign kx   = u_reg[15] ? 16'(ONE - {1'b0, u_reg}) : u_reg;
    assign kx2  = kx * kx;
    assign om_u = ONE - {1'b0, u_reg};
    assign om_h = om_u * {1'b0, h_reg};
    assign p6   = {1'b0, p_reg, 2'b00} + {2'b00, p_reg, 1'b0};
    assign kw   = u_reg[15] ? {1'b0, p_reg[30:15]} : 17'(ONE - 17'(p6[33:16]));

    assign wtw   = 49'(wt_reg * kbuf_rdata);
    assign qprod = q_reg * $signed({1'b0, tw_reg});

    assign nq = $signed({grid_rdata[95], grid_rdata[95:48]})
              + $signed({addq_reg[47], addq_reg});
    assign nw = {1'b0, grid_rdata[47:0]} + {17'd0, tw_reg};
    assign nq_sat = (nq[48] != nq[47]) ? (nq[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                                       : nq[47:0];
    assign nw_sat = nw[48] ? {48{1'b1}} : nw[47:0];

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clr_cmd_next  = clr_cmd_reg;
        m_valid_next  = m_valid_reg;
        px_next = px_reg;  py_next = py_reg;  r_next = r_reg;
        q_next  = q_reg;   wt_next = wt_reg;
        ax_next = ax_reg;  ay_next = ay_reg;
        nxm1_next = nxm1_reg;  nym1_next = nym1_reg;
        a_next = a_reg;  b_next = b_reg;
        r2_next = r2_reg;  sqx_next = sqx_reg;  sqy_next = sqy_reg;
        u_next = u_reg;  h_next = h_reg;  p_next = p_reg;
        sum_next = sum_reg;  tw_next = tw_reg;  addq_next = addq_reg;
        status_next = status_reg;
        rq_next = rq_reg;  rw_next = rw_reg;
        m_status_next = m_status_reg;  m_q_next = m_q_reg;  m_w_next = m_w_reg;
        grid_we    = 1'b0;
        grid_waddr = gaddr;
        grid_wdata = {nq_sat, nw_sat};
        kbuf_we    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {17'd0, sqrt_rsp.root, 16'd0};
        div_req.divisor  = {7'd0, r_reg};
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = d2;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    status_next = STAT_OK;
                    rq_next = '0;
                    rw_next = '0;
                    a_next = '0;
                    b_next = '0;
                    case (cmd_t'(s_command))
                        CMD_DEPOSIT: begin
                            px_next = s_pos_x;
                            py_next = s_pos_y;
                            r_next  = s_radius;
                            q_next  = s_quantity;
                            wt_next = s_weight;
                            state_next = ST_SETUP;
                        end
                        CMD_READ: begin
                            ax_next = s_cell_x;
                            ay_next = s_cell_y;
                            nxm1_next = '0;
                            nym1_next = '0;
                            state_next = ST_RDADDR;
                        end
                        CMD_CLEAR: begin
                            clr_addr_next = '0;
                            clr_cmd_next  = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = clr_addr_reg;
                grid_wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {GRID_AW{1'b1}}) begin
                    state_next = clr_cmd_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_SETUP: begin
                ax_next   = lox[5:0];
                ay_next   = loy[5:0];
                nxm1_next = spanx[2:0];
                nym1_next = spany[2:0];
                r2_next   = r_reg * r_reg;
                sum_next  = '0;
                if (spanx >= 18'(SPAN_MAX) || spany >= 18'(SPAN_MAX)) begin
                    status_next = STAT_SPAN;
                    state_next  = ST_DONE;
                end else if (spanx == '0 && spany == '0) begin
                    tw_next    = wt_reg;
                    state_next = ST_GRD;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                sqx_next   = sqx_full[31:0];
                sqy_next   = sqy_full[31:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (d2 < r2_reg) begin
                    sqrt_req.start = 1'b1;
                    state_next = ST_SQRT;
                end else begin
                    kbuf_we = 1'b1;
                    if (b_reg != nym1_reg) begin
                        b_next = b_reg + 1'b1;
                        state_next = ST_SQ;
                    end else if (a_reg != nxm1_reg) begin
                        a_next = a_reg + 1'b1;
                        b_next = '0;
                        state_next = ST_SQ;
                    end else begin
                        state_next = ST_P1END;
                    end
                end
            end
            ST_SQRT: begin
                if (sqrt_rsp.done) begin
                    div_req.start = 1'b1;
                    state_next = ST_UDIV;
                end
            end
            ST_UDIV: begin
                if (div_rsp.done) begin
                    u_next = div_rsp.quotient[15:0];
                    state_next = ST_KP1;
                end
            end
            ST_KP1: begin
                h_next = kx2[31:16];
                state_next = ST_KP2;
            end
            ST_KP2: begin
                p_next = om_h[30:0];
                state_next = ST_KP3;
            end
            ST_KP3: begin
                kbuf_we  = 1'b1;
                sum_next = sum_reg + SUM_W'(kw);
                if (b_reg != nym1_reg) begin
                    b_next = b_reg + 1'b1;
                    state_next = ST_SQ;
                end else if (a_reg != nxm1_reg) begin
                    a_next = a_reg + 1'b1;
                    b_next = '0;
                    state_next = ST_SQ;
                end else begin
                    state_next = ST_P1END;
                end
            end
            ST_P1END: begin
                a_next = '0;
                b_next = '0;
                if (sum_reg == '0) begin
                    status_next = STAT_EMPTY;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_P2RD;
                end
            end
            ST_P2RD: begin
                state_next = ST_P2MUL;
            end
            ST_P2MUL: begin
                div_req.start    = 1'b1;
                div_req.dividend = wtw;
                div_req.divisor  = sum_reg;
                state_next = ST_TWDIV;
            end
            ST_TWDIV: begin
                div_req.divisor = sum_reg;
                if (div_rsp.done) begin
                    tw_next = div_rsp.quotient[31:0];
                    state_next = ST_GRD;
                end
            end
            ST_GRD: begin
                addq_next  = qprod[63:16];
                state_next = ST_GWR;
            end
            ST_GWR: begin
                grid_we = 1'b1;
                if (b_reg != nym1_reg) begin
                    b_next = b_reg + 1'b1;
                    state_next = ST_P2RD;
                end else if (a_reg != nxm1_reg) begin
                    a_next = a_reg + 1'b1;
                    b_next = '0;
                    state_next = ST_P2RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RDADDR: begin
                state_next = ST_RDDATA;
            end
            ST_RDDATA: begin
                rq_next = grid_rdata[95:48];
                rw_next = grid_rdata[47:0];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_q_next      = rq_reg;
                    m_w_next      = rw_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_cmd_reg  <= 1'b0;
            glog_reg     <= 3'(GRID_LOG2_MAX);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_cmd_reg  <= clr_cmd_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                glog_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        px_reg <= px_next;  py_reg <= py_next;  r_reg <= r_next;
        q_reg  <= q_next;   wt_reg <= wt_next;
        ax_reg <= ax_next;  ay_reg <= ay_next;
        nxm1_reg <= nxm1_next;  nym1_reg <= nym1_next;
        a_reg <= a_next;  b_reg <= b_next;
        r2_reg <= r2_next;  sqx_reg <= sqx_next;  sqy_reg <= sqy_next;
        u_reg <= u_next;  h_reg <= h_next;  p_reg <= p_next;
        sum_reg <= sum_next;  tw_reg <= tw_next;  addq_reg <= addq_next;
        status_reg <= status_next;
        rq_reg <= rq_next;  rw_reg <= rw_next;
        m_status_reg <= m_status_next;  m_q_reg <= m_q_next;  m_w_reg <= m_w_next;
    end

    sph_ram #(
        .WIDTH (2 * GRID_W),
        .DEPTH (1 << GRID_AW)
    ) u_grid_ram (
        .aclk  (aclk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (gaddr),
        .rdata (grid_rdata)
    );

    sph_ram #(
        .WIDTH (KBUF_W),
        .DEPTH (SPAN_MAX * SPAN_MAX)
    ) u_kbuf_ram (
        .aclk  (aclk),
        .we    (kbuf_we),
        .waddr ({a_reg, b_reg}),
        .wdata ((state_reg == ST_KP3) ? kw : '0),
        .raddr ({a_reg, b_reg}),
        .rdata (kbuf_rdata)
    );

    sph_gd_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    sph_gd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_cell_quantity = m_q_reg;
    assign m_cell_weight   = m_w_reg;

    a_grid_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_GWR |-> $past(state_reg) == ST_GRD)
        else $error("grid write without preceding read cycle");

    a_kernel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_KP3 |-> kw <= ONE)
        else $error("kernel value above one");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_UDIV || state_reg == ST_TWDIV))
        else $error("divider finished while not awaited");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken before first finished");

    a_half_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_KP1 && u_reg < HALF |-> kx == u_reg)
        else $error("kernel branch select mismatch");

endmodule
